@@ rtl/core/tbir_pkg.sv @@
// Shared types and constants for the text buffer insert/remove block.
package tbir_pkg;

   localparam int POS_W  = 10;
   localparam int CHAR_W = 8;
   localparam int STAT_W = 2;

   localparam logic [CHAR_W-1:0] FILL_CHAR = 8'h20;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_NULL   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SHIFT,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [POS_W-1:0]    position;
      logic [CHAR_W-1:0]   char_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic [CHAR_W-1:0]   char_out;
      logic [POS_W-1:0]    end_position;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic decode;
      logic read_cell;
      logic commit;
      logic shift_run;
      logic final_wr;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       reject;
      logic       shift_done;
      logic       clear_last;
      logic       rsp_busy;
   } sts_type;

endpackage

@@ rtl/core/tbir_ctrl.sv @@
// Controller state machine for the text buffer insert/remove block.
module tbir_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  tbir_pkg::sts_type sts,
   output tbir_pkg::cmd_type cmd
);
   import tbir_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.reject || sts.opcode == OP_NULL || sts.opcode == OP_READ) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (sts.shift_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            cmd.accept = 1'b1;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (!sts.reject) begin
               if (sts.opcode == OP_READ) begin
                  cmd.read_cell = 1'b1;
               end else if (sts.opcode != OP_NULL) begin
                  cmd.commit = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift_run = 1'b1;
         end
         ST_WRITE: begin
            cmd.final_wr = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = !sts.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/tbir_datapath.sv @@
// Datapath: document store, shift pointers, end mark and result register.
module tbir_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  tbir_pkg::req_type req_data,
   input  logic              rsp_ready,
   input  tbir_pkg::cmd_type cmd,
   output tbir_pkg::sts_type sts,
   output logic              rsp_valid,
   output tbir_pkg::rsp_type rsp_data
);
   import tbir_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;
   localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(CAPACITY - 1);
   localparam logic [ADDR_W-1:0] SHIFT_TOP = ADDR_W'(CAPACITY - 2);
   localparam logic [CMP_W-1:0]  CAP_EXT = CMP_W'(CAPACITY);

   logic [CHAR_W-1:0] mem [CAPACITY];

   // latched transaction
   opcode_type        op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [CHAR_W-1:0] ch_ff;

   logic [ADDR_W-1:0] end_ff;
   logic [ADDR_W-1:0] end_in;
   logic [ADDR_W-1:0] clr_ff;
   logic [ADDR_W-1:0] rp_ff;
   logic [ADDR_W-1:0] remain_ff;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_wa_ff;
   logic [CHAR_W-1:0] rd_data_ff;
   logic [STAT_W-1:0] stat_ff;
   logic              chr_en_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [ADDR_W-1:0] pos_addr;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  end_ext;
   logic [CMP_W-1:0]  next_ext;
   logic              range_err;
   logic              full_err;
   logic [STAT_W-1:0] stat_code;
   logic              step;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic              is_insert;

   assign is_insert = (op_ff == OP_INSERT);
   assign pos_addr  = ADDR_W'(pos_ff);
   assign pos_ext   = CMP_W'(pos_ff);
   assign end_ext   = CMP_W'(end_ff);
   assign next_ext  = (pos_ext <= end_ext) ? end_ext + CMP_W'(1) : pos_ext;
   assign range_err = (op_ff != OP_NULL) && (pos_ext >= CAP_EXT);
   assign full_err  = is_insert && !range_err && (next_ext >= CAP_EXT);
   assign stat_code = range_err ? STAT_RANGE : (full_err ? STAT_FULL : STAT_DONE);

   always_comb begin
      end_in = end_ff;
      if (is_insert) begin
         end_in = ADDR_W'(next_ext);
      end else if (end_ff != '0 && pos_ext <= end_ext) begin
         end_in = end_ff - ADDR_W'(1);
      end
   end

   assign step = cmd.shift_run && (remain_ff != '0);

   // single read and single write port
   always_comb begin
      rd_en   = cmd.read_cell || step;
      rd_addr = cmd.read_cell ? pos_addr : rp_ff;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = FILL_CHAR;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_wa_ff;
         wr_data = rd_data_ff;
      end else if (cmd.final_wr) begin
         wr_en   = 1'b1;
         wr_addr = is_insert ? pos_addr : TOP_ADDR;
         wr_data = is_insert ? ch_ff : FILL_CHAR;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // transaction capture and shift pointers
   always_ff @(posedge clock) begin
      if (cmd.accept && req_valid) begin
         op_ff  <= req_data.opcode;
         pos_ff <= req_data.position;
         ch_ff  <= req_data.char_in;
      end
      if (cmd.decode) begin
         stat_ff   <= stat_code;
         chr_en_ff <= (op_ff == OP_READ) && !range_err;
      end
      if (cmd.commit) begin
         rp_ff     <= is_insert ? SHIFT_TOP : pos_addr + ADDR_W'(1);
         remain_ff <= TOP_ADDR - pos_addr;
      end else if (step) begin
         rp_ff      <= is_insert ? rp_ff - ADDR_W'(1) : rp_ff + ADDR_W'(1);
         remain_ff  <= remain_ff - ADDR_W'(1);
      end
      if (step) begin
         pend_wa_ff <= is_insert ? rp_ff + ADDR_W'(1) : rp_ff - ADDR_W'(1);
      end
      if (cmd.load_rsp) begin
         rsp_ff.status       <= stat_ff;
         rsp_ff.char_out     <= chr_en_ff ? rd_data_ff : '0;
         rsp_ff.end_position <= POS_W'(end_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         end_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) end_ff <= end_in;
         if (cmd.clear_wr) clr_ff <= clr_ff + ADDR_W'(1);
         pend_ff <= step;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.opcode     = op_ff;
      sts.reject     = range_err || full_err;
      sts.shift_done = (remain_ff == '0);
      sts.clear_last = (clr_ff == TOP_ADDR);
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/text_buffer_insert_remove_top.sv @@
// Top level of the text buffer insert/remove block.
// A document of CAPACITY byte cells sits in a single-port-read, single-port-write
// memory, with an end mark beside it. After reset the block first sweeps the
// memory to spaces, one cell a cycle, and req_ready stays low until the sweep
// is done. Transactions are then handled one at a time. Insert and remove move
// every cell from the position to the top end by one place, one memory read and
// one write per cycle, so the time to the result grows as the position falls and
// is set by the memory port. Null, read and rejected transactions skip the shift
// and go from decode straight to the result. A result waits in an output
// register, so the next request can be accepted while the previous result is
// still held; it then completes once that register is free. Positions at or
// beyond CAPACITY are rejected with status 1 (null transactions excepted), an
// insert that would push the end mark to CAPACITY with status 2; in both
// cases the document is untouched. end_position reports the end mark after the
// transaction.
module text_buffer_insert_remove_top #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tbir_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbir_pkg::rsp_type rsp_data
);
   import tbir_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tbir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   tbir_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // only ready while waiting for a transaction
   assign req_ready = cmd.accept;

   // memory port users never overlap
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.read_cell, cmd.shift_run, cmd.final_wr}))
      else $error("memory port commands overlap");

   // one transaction in flight: no second accept straight after the first
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && !rsp_ready))
      else $error("result register overwritten");

   // loading the result register raises rsp_valid next cycle
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("result loaded without valid");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the text buffer insert/remove block.

// Tracks the document and end mark as the block should hold them, and checks results in order.
class doc_scoreboard;
   localparam int CELLS = 1024;

   logic [7:0]        doc_cells [CELLS];
   int unsigned       end_mark;
   tbir_pkg::rsp_type expected_q [$];
   int unsigned       errors;
   int unsigned       checked;
   int unsigned       full_refusals;
   int unsigned       op_seen [4];

   function new();
      foreach (doc_cells[i]) doc_cells[i] = tbir_pkg::FILL_CHAR;
      end_mark      = 0;
      errors        = 0;
      checked       = 0;
      full_refusals = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   // Apply one accepted transaction to the document and queue the result it should give.
   function void note_request(tbir_pkg::req_type r);
      tbir_pkg::rsp_type want;
      int unsigned       pos;
      int unsigned       next_end;
      int                i;
      pos           = r.position;
      want.status   = tbir_pkg::STAT_DONE;
      want.char_out = '0;
      op_seen[int'(r.opcode)]++;
      if (r.opcode != tbir_pkg::OP_NULL && pos >= CELLS) begin
         want.status = tbir_pkg::STAT_RANGE;
      end else begin
         case (r.opcode)
            tbir_pkg::OP_INSERT: begin
               next_end = (pos <= end_mark) ? end_mark + 1 : pos;
               if (next_end >= CELLS) begin
                  want.status = tbir_pkg::STAT_FULL;
                  full_refusals++;
               end else begin
                  end_mark = next_end;
                  for (i = CELLS - 1; i > int'(pos); i--) doc_cells[i] = doc_cells[i-1];
                  doc_cells[pos] = r.char_in;
               end
            end
            tbir_pkg::OP_REMOVE: begin
               if (end_mark != 0 && pos <= end_mark) end_mark--;
               for (i = pos; i + 1 < CELLS; i++) doc_cells[i] = doc_cells[i+1];
               doc_cells[CELLS-1] = tbir_pkg::FILL_CHAR;
            end
            tbir_pkg::OP_READ: begin
               want.char_out = doc_cells[pos];
            end
            default: ;
         endcase
      end
      want.end_position = end_mark[9:0];
      expected_q.push_back(want);
   endfunction

   task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task check_response(tbir_pkg::rsp_type got);
      tbir_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result %h", got));
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status)
         report_mismatch($sformatf("result %0d status %0d, want %0d",
                                   checked, got.status, want.status));
      if (got.char_out !== want.char_out)
         report_mismatch($sformatf("result %0d char_out %h, want %h",
                                   checked, got.char_out, want.char_out));
      if (got.end_position !== want.end_position)
         report_mismatch($sformatf("result %0d end_position %0d, want %0d",
                                   checked, got.end_position, want.end_position));
   endtask
endclass

module tb_top;
   import tbir_pkg::*;

   localparam int DOC_CELLS    = 1024;
   // an insert or remove at cell 0 walks the whole store, plus the control states
   localparam int DRAIN_CYCLES = DOC_CELLS + 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   doc_scoreboard doc_book;
   bit            quiet_tail;   // set for the closing stretch: no idling on either side
   int unsigned   rsp_hold;     // cycles left in the current receiver stall burst

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   text_buffer_insert_remove_top #(
      .CAPACITY (DOC_CELLS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Receiver: takes a result on every edge where valid and ready meet, then
   // decides whether to stall next cycle. Stalls come in bursts of random length.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) doc_book.check_response(rsp_data);
      if (!quiet_tail && rsp_hold == 0 && $urandom_range(0, 4) == 0)
         rsp_hold = $urandom_range(1, 4);
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type make_item(opcode_type op, int unsigned pos, logic [7:0] ch);
      req_type r;
      r.opcode   = op;
      r.position = pos[9:0];
      r.char_in  = ch;
      return r;
   endfunction

   // Mostly well-formed edits: positions inside the text or just past its end,
   // so the document grows and shrinks; the rest land anywhere in the store,
   // which drags the end mark up and now and then fills the store.
   function automatic req_type random_item();
      int unsigned roll;
      int unsigned top;
      int unsigned pos;
      opcode_type  op;
      roll = $urandom_range(0, 99);
      top  = doc_book.end_mark;
      if (roll < 40) begin
         op  = OP_INSERT;
         pos = $urandom_range(0, (top + 1 > DOC_CELLS - 1) ? DOC_CELLS - 1 : top + 1);
      end else if (roll < 70) begin
         op  = OP_REMOVE;
         pos = $urandom_range(0, top);
      end else if (roll < 92) begin
         op  = OP_READ;
         pos = $urandom_range(0, top);
      end else begin
         op  = OP_NULL;
         pos = $urandom_range(0, DOC_CELLS - 1);
      end
      if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, DOC_CELLS - 1);
      return make_item(op, pos, 8'($urandom));
   endfunction

   // Present one transaction and hold it until the block takes it. Valid is
   // left high on return so a back-to-back transaction follows without a gap;
   // otherwise a random idle burst is inserted here.
   task automatic send_item(input req_type r);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      doc_book.note_request(r);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      while (doc_book.pending() != 0) @(posedge clock);
   endtask

   initial begin
      doc_book   = new();
      quiet_tail = 1'b0;
      rsp_hold   = 0;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      rsp_ready  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty document, the end of the store, a full store, and
      // removes at and beyond the end mark. Also waits out the clearing sweep.
      send_item(make_item(OP_READ,   0,    8'h00));  // freshly cleared cell is a space
      send_item(make_item(OP_NULL,   1023, 8'hFF));
      send_item(make_item(OP_REMOVE, 0,    8'hFF));  // empty document: mark stays at zero
      send_item(make_item(OP_INSERT, 0,    8'h00));
      send_item(make_item(OP_INSERT, 0,    8'hFF));
      send_item(make_item(OP_INSERT, 1,    8'h41));
      send_item(make_item(OP_READ,   0,    8'h00));
      send_item(make_item(OP_READ,   1,    8'h00));
      send_item(make_item(OP_READ,   2,    8'h00));
      send_item(make_item(OP_REMOVE, 500,  8'h00));  // beyond the end: mark unchanged
      send_item(make_item(OP_INSERT, 600,  8'h5A));  // beyond the end: mark jumps to it
      send_item(make_item(OP_READ,   600,  8'h00));
      send_item(make_item(OP_INSERT, 1023, 8'h7E));  // mark reaches the top cell
      send_item(make_item(OP_INSERT, 0,    8'h11));  // store full
      send_item(make_item(OP_INSERT, 1023, 8'h22));  // store full at the top
      send_item(make_item(OP_READ,   1023, 8'h00));
      send_item(make_item(OP_REMOVE, 1023, 8'h00));
      send_item(make_item(OP_REMOVE, 0,    8'h00));  // full-length shift down
      send_item(make_item(OP_NULL,   0,    8'h00));
      send_item(make_item(OP_READ,   1023, 8'h00));  // top refilled with a space

      repeat (280) send_item(random_item());

      // Let the block run dry before carrying on.
      req_valid <= 1'b0;
      wait_all_results();

      repeat (200) send_item(random_item());

      // Closing stretch at full rate on both sides.
      quiet_tail = 1'b1;
      repeat (80) send_item(random_item());
      req_valid <= 1'b0;

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d inserts, %0d removes, %0d reads, %0d nulls",
               doc_book.checked, doc_book.op_seen[int'(OP_INSERT)],
               doc_book.op_seen[int'(OP_REMOVE)], doc_book.op_seen[int'(OP_READ)],
               doc_book.op_seen[int'(OP_NULL)]);
      $display("%0d inserts refused on a full store; %0d mismatches",
               doc_book.full_refusals, doc_book.errors);
      if (doc_book.errors == 0) begin
         $display("text_buffer_insert_remove_top regression: pass");
      end else begin
         $display("text_buffer_insert_remove_top regression: fail");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #50000000;
      $display("Timeout with %0d results outstanding", doc_book.pending());
      $display("text_buffer_insert_remove_top regression: fail");
      $finish;
   end

endmodule
